@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile away when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ rtl/core/tcf_pkg.sv @@
// ----------------------------------------------------------------------------
// Three-class queue package
// Types, sizes and codes shared by the queue, the service log and the top.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int LOG_DEPTH   = 32;
  localparam int NUM_CLASSES = 3;

  localparam int ID_W    = 16;
  localparam int CLS_W   = 2;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QADDR_W = $clog2(NUM_CLASSES * QUEUE_DEPTH);
  localparam int LIDX_W  = $clog2(LOG_DEPTH);
  localparam int LCNT_W  = $clog2(LOG_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_SERVE   = 2'd1,
    OP_DUMP    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_SERVED    = 3'd2,
    ST_MARKER    = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_LOG_EMPTY = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SERVE,
    S_DUMP
  } state_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [CLS_W-1:0] queue_class;
    logic [ID_W-1:0]  customer_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ID_W-1:0]  entry_id;
    logic [CLS_W-1:0] entry_class;
    logic             entry_is_marker;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             marker;
    logic [CLS_W-1:0] cls;
    logic [ID_W-1:0]  id;
  } log_entry_t;

  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [CLS_W-1:0] cls;
    logic [ID_W-1:0]  id;
  } qreq_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qsts_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    log_entry_t entry;
  } lreq_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lsts_t;

endpackage

@@ rtl/core/three_class_fifo_with_service_log.sv @@
// ----------------------------------------------------------------------------
// Three-class FIFO with service log
// Three customer queues (elder, adult, child) and a LIFO log of served items.
//
// Items enter on in_valid_i/in_stall_o and results leave on
// out_valid_o/out_stall_i; a transfer happens when valid is high and stall is
// low. Each item carries an opcode, a class and a customer identifier.
// An enqueue loads its result into the output register when accepted. A serve
// reads the oldest identifier from the queue memory, then pushes it into the
// log and loads its result. A dump of N entries gives N results, newest first,
// one per cycle after the newest entry is read and while the receiver does not
// stall, with last set on the final one; an empty log gives a single result.
// OP_NONE, or a bad class for enqueue or serve, is accepted with no result.
// A new item is taken once the previous one has placed its final result in
// the output register, at an edge where that register is empty or being read.
// A receiver stall holds the output register and, through it, the whole
// block; nothing is lost. Reset empties all queues and the log at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_class_fifo_with_service_log
  import tcf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e           state_q, state_d;
  logic [CLS_W-1:0] cls_q, cls_d;
  logic             hit_q, hit_d;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             out_free;
  logic             accept;
  logic             cls_ok;
  logic             load;
  out_item_t        load_item;
  qreq_t            qreq;
  qsts_t            qsts;
  logic [ID_W-1:0]  qdata;
  lreq_t            lreq;
  lsts_t            lsts;
  log_entry_t       ldata;

  tcf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (qreq),
    .sts_o  (qsts),
    .data_o (qdata)
  );

  tcf_log u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lreq),
    .sts_o  (lsts),
    .data_o (ldata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign cls_ok     = (in_item_i.queue_class < CLS_W'(NUM_CLASSES));

  always_comb begin
    state_d = state_q;
    cls_d   = cls_q;
    hit_d   = hit_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cls_d = in_item_i.queue_class;
          hit_d = !qsts.empty;
          if ((in_item_i.opcode == OP_SERVE) && cls_ok) begin
            state_d = S_SERVE;
          end else if ((in_item_i.opcode == OP_DUMP) && !lsts.empty) begin
            state_d = S_DUMP;
          end
        end
      end
      S_SERVE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free && lsts.empty) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    load      = 1'b0;
    load_item = '0;
    qreq      = '0;
    lreq      = '0;
    qreq.cls  = in_item_i.queue_class;
    qreq.id   = in_item_i.customer_id;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.opcode)
            OP_ENQUEUE: begin
              if (cls_ok) begin
                load                  = 1'b1;
                load_item.status      = qsts.full ? ST_FULL : ST_QUEUED;
                load_item.entry_id    = in_item_i.customer_id;
                load_item.entry_class = in_item_i.queue_class;
                load_item.last        = 1'b1;
                qreq.enq              = !qsts.full;
              end
            end
            OP_SERVE: begin
              qreq.deq = cls_ok && !qsts.empty;
            end
            OP_DUMP: begin
              if (lsts.empty) begin
                load                = 1'b1;
                load_item.status    = ST_LOG_EMPTY;
                load_item.last      = 1'b1;
              end else begin
                lreq.pop = 1'b1;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      S_SERVE: begin
        qreq.cls = cls_q;
        if (out_free) begin
          lreq.entry.id     = hit_q ? qdata : '0;
          lreq.entry.cls    = cls_q;
          lreq.entry.marker = !hit_q;
          lreq.push         = !lsts.full;
          load                      = 1'b1;
          load_item.status          = lsts.full ? ST_OVERFLOW :
                                      (hit_q ? ST_SERVED : ST_MARKER);
          load_item.entry_id        = lreq.entry.id;
          load_item.entry_class     = cls_q;
          load_item.entry_is_marker = !hit_q;
          load_item.last            = 1'b1;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load                      = 1'b1;
          load_item.status          = ST_ENTRY;
          load_item.entry_id        = ldata.id;
          load_item.entry_class     = ldata.cls;
          load_item.entry_is_marker = ldata.marker;
          load_item.last            = lsts.empty;
          lreq.pop                  = !lsts.empty;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cls_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      hit_q   <= hit_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= load_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_NEVER(a_no_enq_and_deq, clk_i, rst_ni, qreq.enq && qreq.deq, "Queue enqueue and dequeue at once.")
  `ASSERT_PROP(a_dump_ends, clk_i, rst_ni, (state_q == S_DUMP) && out_free && lsts.empty |=> (state_q == S_IDLE), "Dump did not finish after the final entry.")
  `ASSERT_PROP(a_serve_one_cycle, clk_i, rst_ni, (state_q == S_SERVE) && out_free |-> load && load_item.last, "Serve did not produce its final item.")
  `ASSERT_PROP(a_empty_log_last, clk_i, rst_ni, out_valid_o && (out_item_o.status == ST_LOG_EMPTY) |-> out_item_o.last, "Empty-log item not marked last.")

endmodule

@@ rtl/core/tcf_queue.sv @@
// ----------------------------------------------------------------------------
// Class queue store
// Three circular FIFOs sharing one synchronous memory, with their head, tail
// and occupancy registers. Read data appears in the cycle after a dequeue.
// ----------------------------------------------------------------------------
module tcf_queue
  import tcf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qreq_t           req_i,
  output qsts_t           sts_o,
  output logic [ID_W-1:0] data_o
);

  logic [ID_W-1:0]   mem_q [NUM_CLASSES * QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_q [NUM_CLASSES];
  logic [QPTR_W-1:0] tail_q [NUM_CLASSES];
  logic [QCNT_W-1:0] count_q [NUM_CLASSES];
  logic [ID_W-1:0]   rdata_q;

  logic [CLS_W-1:0]  sel;
  logic [QPTR_W-1:0] head_nxt;
  logic [QPTR_W-1:0] tail_nxt;
  logic [QADDR_W-1:0] base;
  logic [QADDR_W-1:0] waddr;
  logic [QADDR_W-1:0] raddr;

  always_comb begin
    sel = (req_i.cls < CLS_W'(NUM_CLASSES)) ? req_i.cls : '0;
    head_nxt = (head_q[sel] == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[sel] + 1'b1;
    tail_nxt = (tail_q[sel] == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q[sel] + 1'b1;
    base  = QADDR_W'(sel) * QADDR_W'(QUEUE_DEPTH);
    waddr = base + QADDR_W'(tail_q[sel]);
    raddr = base + QADDR_W'(head_q[sel]);
    sts_o.full  = (count_q[sel] == QCNT_W'(QUEUE_DEPTH));
    sts_o.empty = (count_q[sel] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]  <= '0;
        tail_q[c]  <= '0;
        count_q[c] <= '0;
      end
    end else if (req_i.enq) begin
      tail_q[sel]  <= tail_nxt;
      count_q[sel] <= count_q[sel] + 1'b1;
    end else if (req_i.deq) begin
      head_q[sel]  <= head_nxt;
      count_q[sel] <= count_q[sel] - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.enq) begin
      mem_q[waddr] <= req_i.id;
    end
    if (req_i.deq) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign data_o = rdata_q;

endmodule

@@ rtl/core/tcf_log.sv @@
// ----------------------------------------------------------------------------
// Service log
// A LIFO of served entries held in one synchronous memory with a fill count.
// A pop reads the newest entry, which appears in the cycle after the pop.
// ----------------------------------------------------------------------------
module tcf_log
  import tcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lreq_t      req_i,
  output lsts_t      sts_o,
  output log_entry_t data_o
);

  log_entry_t        mem_q [LOG_DEPTH];
  log_entry_t        rdata_q;
  logic [LCNT_W-1:0] count_q;
  logic [LCNT_W-1:0] count_dec;

  assign count_dec   = count_q - 1'b1;
  assign sts_o.full  = (count_q == LCNT_W'(LOG_DEPTH));
  assign sts_o.empty = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (req_i.push && !sts_o.full) begin
      count_q <= count_q + 1'b1;
    end else if (req_i.pop && !sts_o.empty) begin
      count_q <= count_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push && !sts_o.full) begin
      mem_q[count_q[LIDX_W-1:0]] <= req_i.entry;
    end
    if (req_i.pop && !sts_o.empty) begin
      rdata_q <= mem_q[count_dec[LIDX_W-1:0]];
    end
  end

  assign data_o = rdata_q;

endmodule
